// ----- rtl/dlkm_pkg.sv -----
// Shared types and constants of the dual-LFSR keystream masker.
package dlkm_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned ActionW    = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned SeedShortW = 12;
  localparam int unsigned SeedHighW  = 36;
  localparam int unsigned SeedLowW   = 64;
  localparam int unsigned LongStages = SeedHighW + SeedLowW;
  localparam int unsigned LongTap    = 36;
  localparam int unsigned StepsPerByte = 8;

  localparam int unsigned ShortStagesDef = 12;

  localparam logic [SeedShortW-1:0] SeedShortRst = 12'hD4B;
  localparam logic [SeedHighW-1:0]  SeedHighRst  = 36'hABFCBBAEA;
  localparam logic [SeedLowW-1:0]   SeedLowRst   = 64'hAAFEBBECFEBAAFCA;

  localparam logic [CfgIdxW-1:0] CfgSeedShort = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSeedHigh  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSeedLow   = 2'd2;

  typedef enum logic [ActionW-1:0] {
    ACT_MASK   = 2'd0,
    ACT_BIT    = 2'd1,
    ACT_RELOAD = 2'd2,
    ACT_IDLE   = 2'd3
  } action_e;

  typedef struct packed {
    action_e          action;
    logic [DataW-1:0] data_in;
  } item_t;

  typedef struct packed {
    logic [SeedShortW-1:0] seed_short;
    logic [SeedHighW-1:0]  seed_long_high;
    logic [SeedLowW-1:0]   seed_long_low;
  } seeds_t;

endpackage

// ----- rtl/dlkm_intf.sv -----
// Valid/ready channel interfaces of the dual-LFSR keystream masker.
interface dlkm_in_if;
  logic                           valid;
  logic                           ready;
  logic [dlkm_pkg::ActionW-1:0]   action;
  logic [dlkm_pkg::DataW-1:0]     data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink (input valid, input action, input data_in, output ready);
endinterface

interface dlkm_out_if;
  logic                       valid;
  logic                       ready;
  logic [dlkm_pkg::DataW-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink (input valid, input data_out, output ready);
endinterface

interface dlkm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dlkm_pkg::CfgIdxW-1:0]  index;
  logic [dlkm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/dlkm_seed_regs.sv -----
// Seed registers written through the configuration channel.
module dlkm_seed_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  dlkm_cfg_if.sink         cfg,
  output dlkm_pkg::seeds_t seeds_o
);

  dlkm_pkg::seeds_t seeds_q, seeds_d;

  assign cfg.ready = 1'b1;

  always_comb begin
    seeds_d = seeds_q;
    if (cfg.valid) begin
      case (cfg.index)
        dlkm_pkg::CfgSeedShort: seeds_d.seed_short = cfg.data[dlkm_pkg::SeedShortW-1:0];
        dlkm_pkg::CfgSeedHigh:  seeds_d.seed_long_high = cfg.data[dlkm_pkg::SeedHighW-1:0];
        dlkm_pkg::CfgSeedLow:   seeds_d.seed_long_low = cfg.data[dlkm_pkg::SeedLowW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeds_q.seed_short     <= dlkm_pkg::SeedShortRst;
      seeds_q.seed_long_high <= dlkm_pkg::SeedHighRst;
      seeds_q.seed_long_low  <= dlkm_pkg::SeedLowRst;
    end else begin
      seeds_q <= seeds_d;
    end
  end

  assign seeds_o = seeds_q;

`ifndef SYNTH
  a_unknown_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.valid && cfg.index != dlkm_pkg::CfgSeedShort && cfg.index != dlkm_pkg::CfgSeedHigh
    && cfg.index != dlkm_pkg::CfgSeedLow |=> $stable(seeds_q))
    else $error("seed changed on a write beyond the register list");
  a_short_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.valid && cfg.index == dlkm_pkg::CfgSeedShort
    |=> seeds_q.seed_short == $past(cfg.data[dlkm_pkg::SeedShortW-1:0])
        && $stable(seeds_q.seed_long_low))
    else $error("short seed write went astray");
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.valid |=> $stable(seeds_q))
    else $error("seeds changed without a write");
`endif

endmodule

// ----- rtl/dlkm_lfsr_core.sv -----
// Both LFSRs, eight unrolled steps per byte and the result byte of one item.
module dlkm_lfsr_core #(
  parameter int unsigned SHORT_STAGES = dlkm_pkg::ShortStagesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  dlkm_pkg::item_t            item_i,
  input  dlkm_pkg::seeds_t           seeds_i,
  output logic [dlkm_pkg::DataW-1:0] data_out_o
);

  localparam int unsigned PadW = (SHORT_STAGES > dlkm_pkg::SeedShortW) ?
                                 SHORT_STAGES : dlkm_pkg::SeedShortW;
  localparam int unsigned Steps = dlkm_pkg::StepsPerByte;
  localparam int unsigned LongW = dlkm_pkg::LongStages;

  // Upper stages of a short register wider than its seed load as zero.
  function automatic logic [SHORT_STAGES-1:0] fit_short(
    input logic [dlkm_pkg::SeedShortW-1:0] seed
  );
    logic [PadW-1:0] pad;
    pad = PadW'(seed);
    return pad[SHORT_STAGES-1:0];
  endfunction

  logic [SHORT_STAGES-1:0] short_q, short_d;
  logic [LongW-1:0]        long_q, long_d;
  logic [SHORT_STAGES-1:0] short_chain [Steps+1];
  logic [LongW-1:0]        long_chain [Steps+1];
  logic [Steps-1:0]        ks_byte;
  logic [SHORT_STAGES-1:0] short_reload;
  logic [LongW-1:0]        long_reload;

  assign short_reload = fit_short(seeds_i.seed_short);
  assign long_reload  = {seeds_i.seed_long_high, seeds_i.seed_long_low};

  // Each step shifts right and inserts the feedback at the top stage; the
  // keystream bit is the xor of both feedback bits.
  always_comb begin
    short_chain[0] = short_q;
    long_chain[0]  = long_q;
    for (int unsigned k = 0; k < Steps; k++) begin
      ks_byte[k] = short_chain[k][0] ^ short_chain[k][1]
                   ^ long_chain[k][0] ^ long_chain[k][dlkm_pkg::LongTap];
      short_chain[k+1] = {short_chain[k][0] ^ short_chain[k][1],
                          short_chain[k][SHORT_STAGES-1:1]};
      long_chain[k+1]  = {long_chain[k][0] ^ long_chain[k][dlkm_pkg::LongTap],
                          long_chain[k][LongW-1:1]};
    end
  end

  always_comb begin
    short_d    = short_q;
    long_d     = long_q;
    data_out_o = '0;
    case (item_i.action)
      dlkm_pkg::ACT_MASK: begin
        short_d    = short_chain[Steps];
        long_d     = long_chain[Steps];
        data_out_o = item_i.data_in ^ ks_byte;
      end
      dlkm_pkg::ACT_BIT: begin
        short_d    = short_chain[1];
        long_d     = long_chain[1];
        data_out_o = {{(dlkm_pkg::DataW-1){1'b0}}, ks_byte[0]};
      end
      dlkm_pkg::ACT_RELOAD: begin
        short_d = short_reload;
        long_d  = long_reload;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= fit_short(dlkm_pkg::SeedShortRst);
      long_q  <= {dlkm_pkg::SeedHighRst, dlkm_pkg::SeedLowRst};
    end else if (step_i) begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

`ifndef SYNTH
  a_hold_without_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(short_q) && $stable(long_q))
    else $error("LFSR state moved without an item");
  a_reload_loads_seeds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == dlkm_pkg::ACT_RELOAD
    |=> long_q == $past(long_reload) && short_q == $past(short_reload))
    else $error("reload did not restore the seeds");
  a_idle_code_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == dlkm_pkg::ACT_IDLE |=> $stable(long_q) && $stable(short_q))
    else $error("unused action changed LFSR state");
`endif

endmodule

// ----- rtl/dual_lfsr_keystream_masker.sv -----
// Top level of the dual-LFSR keystream masker: input stage, core and result stage.
// A beat accepted into the input stage is processed by the core when it advances, and
// its result is registered in the result stage. Throughput: one beat per cycle unless
// the result stage stalls; the eight LFSR steps of a byte are unrolled xor logic.
// The input stage keeps accepting while a result waits, until it holds a beat itself.
// Reset (rst_ni low, asynchronous) loads the seed registers and both LFSRs with
// their default seeds and empties both stages.
module dual_lfsr_keystream_masker #(
  parameter int unsigned SHORT_STAGES = dlkm_pkg::ShortStagesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dlkm_in_if.sink   in_i,
  dlkm_out_if.source out_o,
  dlkm_cfg_if.sink  cfg_i
);

  logic                       in_valid_q, in_valid_d;
  dlkm_pkg::item_t            item_q;
  logic                       out_valid_q, out_valid_d;
  logic [dlkm_pkg::DataW-1:0] out_data_q;
  logic [dlkm_pkg::DataW-1:0] core_data;
  logic                       advance;
  logic                       in_take;
  dlkm_pkg::seeds_t           seeds;

  dlkm_seed_regs u_seed_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg     (cfg_i),
    .seeds_o (seeds)
  );

  dlkm_lfsr_core #(
    .SHORT_STAGES (SHORT_STAGES)
  ) u_lfsr_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (item_q),
    .seeds_i    (seeds),
    .data_out_o (core_data)
  );

  // The held beat moves on whenever the result stage is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.action  <= dlkm_pkg::action_e'(in_i.action);
      item_q.data_in <= in_i.data_in;
    end
    if (advance) begin
      out_data_q <= core_data;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;

`ifndef SYNTH
  a_stalled_beat_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(item_q))
    else $error("held input beat lost while the result stage was blocked");
  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat produced no result");
  a_narrow_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.action != dlkm_pkg::ACT_MASK
    |=> out_data_q[dlkm_pkg::DataW-1:1] == '0)
    else $error("non-mask result has upper bits set");
  a_empty_stage_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("empty input stage refused a beat");
`endif

endmodule
